### design/ntpcd_pkg.sv
// Package with shared types, constants and calendar helpers for the NTP date/time converter.
package ntpcd_pkg;

    // Field widths fixed by the interface.
    localparam int NTP_W    = 32;
    localparam int OFF_W    = 11;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 11;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int TDATA_W  = 40;

    // Internal widths: seconds since 1970 fit in 31 bits, days in 15 bits.
    localparam int SECS_W   = 31;
    localparam int DAYS_W   = 15;
    localparam int SUM_W    = 34;

    localparam logic [NTP_W-1:0] UNIX_EPOCH_NTP = 32'd2208988800;

    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;

    // Quotient bit counts of the three divisions.
    localparam int DAY_QB  = 15;
    localparam int HOUR_QB = 5;
    localparam int MIN_QB  = 6;

    // Each division drops the power-of-two factor of its divisor first, then
    // multiplies by a rounded-up reciprocal and keeps the top bits. The
    // constants are exact over the operand ranges given beside them.
    localparam int DAY_PRE    = 7;                   // 86400 = 128 * 675
    localparam int DAY_X_W    = SECS_W - DAY_PRE;    // seconds / 128, 24 bits
    localparam int DAY_RCP_W  = 25;
    localparam int DAY_RCP_SH = 34;
    localparam int DAY_P_W    = DAY_X_W + DAY_RCP_W;
    localparam logic [DAY_RCP_W-1:0] DAY_RCP = 25'd25451659;

    localparam int TOD_W       = 17;                 // time of day, below 86400
    localparam int HOUR_PRE    = 4;                  // 3600 = 16 * 225
    localparam int HOUR_X_W    = TOD_W - HOUR_PRE;
    localparam int HOUR_RCP_W  = 14;
    localparam int HOUR_RCP_SH = 21;
    localparam int HOUR_P_W    = HOUR_X_W + HOUR_RCP_W;
    localparam logic [HOUR_RCP_W-1:0] HOUR_RCP = 14'd9321;

    localparam int MINS_W     = 12;                  // seconds within the hour, below 3600
    localparam int MIN_PRE    = 2;                   // 60 = 4 * 15
    localparam int MIN_X_W    = MINS_W - MIN_PRE;
    localparam int MIN_RCP_W  = 11;
    localparam int MIN_RCP_SH = 14;
    localparam int MIN_P_W    = MIN_X_W + MIN_RCP_W;
    localparam logic [MIN_RCP_W-1:0] MIN_RCP = 11'd1093;

    // Calendar starting point and its residues modulo 100 and 400.
    localparam logic [YEAR_W-1:0] YEAR_BASE = 11'd1970;
    localparam logic [6:0]        Y100_BASE = 7'd70;
    localparam logic [8:0]        Y400_BASE = 9'd370;
    localparam logic [6:0]        Y100_LAST = 7'd99;
    localparam logic [8:0]        Y400_LAST = 9'd399;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_DAY,
        ST_HOUR_START,
        ST_DIV_HOUR,
        ST_MIN_START,
        ST_DIV_MIN,
        ST_CAL_START,
        ST_YEAR,
        ST_MONTH,
        ST_FINISH
    } ntpcd_state_t;

    typedef struct packed {
        logic load;
        logic div_day;
        logic start_hour;
        logic div_hour;
        logic start_min;
        logic div_min;
        logic cal_start;
        logic year_step;
        logic month_step;
        logic emit;
    } ntpcd_cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
        logic out_free;
    } ntpcd_status_t;

    // Length in days of a zero-based month.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m) inside
            MONTH_FEB:                               len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default:                                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### design/ntpcd_ctrl.sv
// Controller state machine that sequences the divisions and calendar walk.
module ntpcd_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  ntpcd_pkg::ntpcd_status_t status,
    output ntpcd_pkg::ntpcd_cmd_t    cmd
);
    import ntpcd_pkg::*;

    ntpcd_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (s_tvalid) state_next = ST_DIV_DAY;
            ST_DIV_DAY:    state_next = ST_HOUR_START;
            ST_HOUR_START: state_next = ST_DIV_HOUR;
            ST_DIV_HOUR:   state_next = ST_MIN_START;
            ST_MIN_START:  state_next = ST_DIV_MIN;
            ST_DIV_MIN:    state_next = ST_CAL_START;
            ST_CAL_START:  state_next = ST_YEAR;
            ST_YEAR:       if (status.year_done) state_next = ST_MONTH;
            ST_MONTH:      if (status.month_done) state_next = ST_FINISH;
            ST_FINISH:     if (status.out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DIV_DAY:    cmd.div_day    = 1'b1;
            ST_HOUR_START: cmd.start_hour = 1'b1;
            ST_DIV_HOUR:   cmd.div_hour   = 1'b1;
            ST_MIN_START:  cmd.start_min  = 1'b1;
            ST_DIV_MIN:    cmd.div_min    = 1'b1;
            ST_CAL_START:  cmd.cal_start  = 1'b1;
            ST_YEAR:       cmd.year_step  = !status.year_done;
            ST_MONTH:      cmd.month_step = !status.month_done;
            ST_FINISH:     cmd.emit       = status.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### design/ntpcd_datapath.sv
// Datapath: offset register, reciprocal dividers, year and month walk, output register.
module ntpcd_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic signed [ntpcd_pkg::OFF_W-1:0] cfg_wr_data,
    input  logic [ntpcd_pkg::NTP_W-1:0]        ntp_seconds,
    input  ntpcd_pkg::ntpcd_cmd_t              cmd,
    output ntpcd_pkg::ntpcd_status_t           status,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ntpcd_pkg::TDATA_W-1:0]      m_tdata,
    output logic                               m_tuser
);
    import ntpcd_pkg::*;

    logic signed [OFF_W-1:0] utc_off_reg;

    logic [SECS_W-1:0] rem_reg, rem_next;
    logic [DAY_QB-1:0] quo_reg, quo_next;
    logic              valid_reg, valid_next;

    logic [DAYS_W-1:0]  days_reg, days_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [6:0]         y100_reg, y100_next;
    logic [8:0]         y400_reg, y400_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [HOUR_W-1:0]  hour_reg, hour_next;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_user_reg;
    logic [TDATA_W-1:0] out_data_reg;

    logic signed [SUM_W-1:0] off_ext, off_sec, base, sum;
    logic [SECS_W-1:0]       secs;
    logic [DAY_P_W-1:0]      day_prod;
    logic [HOUR_P_W-1:0]     hour_prod;
    logic [MIN_P_W-1:0]      min_prod;
    logic [SECS_W-1:0]       day_back, hour_back, min_back;
    logic                    leap;
    logic [8:0]              ylen;
    logic [DAY_W-1:0]        mlen;
    logic [DAY_W-1:0]        day_out;
    logic [MONTH_W-1:0]      month_out;

    // Seconds since 1970 in local time, clamped at zero.
    always_comb begin
        off_ext = {{(SUM_W - OFF_W){utc_off_reg[OFF_W-1]}}, utc_off_reg};
        off_sec = (off_ext <<< 6) - (off_ext <<< 2);
        base    = $signed({2'b00, ntp_seconds}) - $signed({2'b00, UNIX_EPOCH_NTP});
        sum     = base + off_sec;
        secs    = sum[SUM_W-1] ? '0 : sum[SECS_W-1:0];
    end

    // Quotients by reciprocal multiplication; the remainder follows in the next
    // cycle from the registered quotient.
    always_comb begin
        day_prod  = DAY_P_W'(rem_reg[SECS_W-1:DAY_PRE]) * DAY_P_W'(DAY_RCP);
        hour_prod = HOUR_P_W'(rem_reg[TOD_W-1:HOUR_PRE]) * HOUR_P_W'(HOUR_RCP);
        min_prod  = MIN_P_W'(rem_reg[MINS_W-1:MIN_PRE]) * MIN_P_W'(MIN_RCP);
        day_back  = SECS_W'(quo_reg) * SECS_W'(SECS_PER_DAY);
        hour_back = SECS_W'(quo_reg) * SECS_W'(SECS_PER_HOUR);
        min_back  = SECS_W'(quo_reg) * SECS_W'(SECS_PER_MIN);
    end

    always_comb begin
        leap = ((year_reg[1:0] == 2'b00) && (y100_reg != 7'd0)) || (y400_reg == 9'd0);
        ylen = leap ? 9'd366 : 9'd365;
        mlen = month_len(month_reg, leap);
    end

    always_comb begin
        status.year_done  = (days_reg < DAYS_W'(ylen));
        status.month_done = (month_reg == MONTH_DEC) || (days_reg < DAYS_W'(mlen));
        status.out_free   = !out_valid_reg || m_tready;
    end

    always_comb begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        valid_next = valid_reg;
        days_next  = days_reg;
        year_next  = year_reg;
        y100_next  = y100_reg;
        y400_next  = y400_reg;
        month_next = month_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;

        if (cmd.load) begin
            rem_next   = secs;
            valid_next = (ntp_seconds >= UNIX_EPOCH_NTP);
        end
        if (cmd.div_day) begin
            quo_next = day_prod[DAY_RCP_SH +: DAY_QB];
        end
        if (cmd.start_hour) begin
            days_next = quo_reg;
            rem_next  = rem_reg - day_back;
        end
        if (cmd.div_hour) begin
            quo_next = DAY_QB'(hour_prod[HOUR_RCP_SH +: HOUR_QB]);
        end
        if (cmd.start_min) begin
            hour_next = quo_reg[HOUR_W-1:0];
            rem_next  = rem_reg - hour_back;
        end
        if (cmd.div_min) begin
            quo_next = DAY_QB'(min_prod[MIN_RCP_SH +: MIN_QB]);
        end
        if (cmd.cal_start) begin
            min_next   = quo_reg[MIN_W-1:0];
            sec_next   = SEC_W'(rem_reg - min_back);
            year_next  = YEAR_BASE;
            y100_next  = Y100_BASE;
            y400_next  = Y400_BASE;
            month_next = MONTH_JAN;
        end
        if (cmd.year_step) begin
            days_next = days_reg - DAYS_W'(ylen);
            year_next = year_reg + YEAR_W'(1);
            y100_next = (y100_reg == Y100_LAST) ? 7'd0 : (y100_reg + 7'd1);
            y400_next = (y400_reg == Y400_LAST) ? 9'd0 : (y400_reg + 9'd1);
        end
        if (cmd.month_step) begin
            days_next  = days_reg - DAYS_W'(mlen);
            month_next = month_reg + MONTH_W'(1);
        end
    end

    always_comb begin
        day_out   = days_reg[DAY_W-1:0] + DAY_W'(1);
        month_out = month_reg + MONTH_W'(1);
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utc_off_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                utc_off_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        valid_reg <= valid_next;
        days_reg  <= days_next;
        year_reg  <= year_next;
        y100_reg  <= y100_next;
        y400_reg  <= y400_next;
        month_reg <= month_next;
        hour_reg  <= hour_next;
        min_reg   <= min_next;
        sec_reg   <= sec_next;
        if (cmd.emit) begin
            out_user_reg <= valid_reg;
            if (valid_reg) begin
                out_data_reg <= {3'b000, sec_reg, min_reg, hour_reg,
                                 year_reg, month_out, day_out};
            end else begin
                out_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

### design/ntp_seconds_to_civil_datetime.sv
// Top level of the NTP seconds to civil date and time converter.
//
//  Channel   Direction  Payload                                   Handshake
//  s_*       in         tdata[31:0] ntp_seconds                   tvalid/tready
//  m_*       out        tdata: day, month, year, hour, min, sec   tvalid/tready
//                       tuser: valid_res
//  cfg_*     in         wr_data[10:0] utc_offset_minutes (signed) wr_en only
//
// One item is converted at a time. After the input transfer the block finds the day
// count, the hour and the minute in turn; each is a reciprocal multiplication into
// the quotient register and then the remainder step. Years and months are walked
// one per cycle after that, up to 66 whole years past 1970, then the months.
// Reset is synchronous and active low; it clears the offset register to zero and
// empties the output register. The result waits in the output register while the
// next input transfer is taken; a stalled result only holds back the following one.
module ntp_seconds_to_civil_datetime (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration: utc_offset_minutes.
    input  logic                               cfg_wr_en,
    input  logic signed [ntpcd_pkg::OFF_W-1:0] cfg_wr_data,
    // Input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ntpcd_pkg::NTP_W-1:0]        s_tdata,   // [31:0] ntp_seconds
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [4:0] day_of_month, [8:5] month_number, [19:9] year_number,
    // [24:20] hour_of_day, [30:25] minute_of_hour, [36:31] second_of_minute,
    // [39:37] zero.
    output logic [ntpcd_pkg::TDATA_W-1:0]      m_tdata,
    output logic                               m_tuser    // [0] valid_res
);
    import ntpcd_pkg::*;

    ntpcd_cmd_t    cmd;
    ntpcd_status_t status;

    // The controller steps through the divisions and the calendar walk.
    ntpcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the offset, the working registers and the output register.
    ntpcd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ntp_seconds (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

### design/ntpcd_checker.sv
// Port-level checker for the NTP date/time converter and its bind statement.
module ntpcd_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [ntpcd_pkg::TDATA_W-1:0]      m_tdata,
    input logic                               m_tuser
);
    import ntpcd_pkg::*;

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One item at a time: the input closes after a transfer.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // Results before the Unix epoch carry no date or time.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("invalid result with nonzero fields");

    // Valid results hold a plausible calendar date and time of day.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[4:0] != 5'd0 && m_tdata[8:5] != 4'd0 && m_tdata[8:5] <= 4'd12 &&
            m_tdata[19:9] >= 11'd1970 && m_tdata[19:9] <= 11'd2036 &&
            m_tdata[24:20] <= 5'd23 && m_tdata[30:25] <= 6'd59 &&
            m_tdata[36:31] <= 6'd59 && m_tdata[39:37] == 3'd0)
        else $error("valid result out of range");

endmodule

bind ntp_seconds_to_civil_datetime ntpcd_checker u_ntpcd_checker (.*);
